FILE: sv/bwspt_pkg.sv
// Shared types, codes and wait-table helpers for the bus wait-state and prefetch timer.
package bwspt_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_WAIT_CONTROL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EWRAM_WAIT   = 2'd1;

    localparam int unsigned PF_EN_BIT = 14;
    localparam logic [3:0]  EWRAM_KEEP_DEFAULT = 4'd15;
    localparam logic [4:0]  EWRAM_DEFAULT_WAIT = 5'd2;
    localparam logic [3:0]  EWRAM_RESET_FIELD  = 4'd13;

    localparam logic [3:0] REGION_WRAM_EXT = 4'd2;
    localparam logic [3:0] REGION_PAL_RAM  = 4'd5;
    localparam logic [3:0] REGION_VID_RAM  = 4'd6;
    localparam logic [3:0] REGION_ROM_LO   = 4'd8;
    localparam logic [3:0] REGION_ROM_HI   = 4'd13;
    localparam logic [3:0] REGION_BACKUP   = 4'd14;

    localparam logic [4:0] FIRST_WAIT [4] = '{5'd4, 5'd3, 5'd2, 5'd8};
    localparam logic [4:0] SEQ_WAIT   [6] = '{5'd2, 5'd1, 5'd4, 5'd1, 5'd8, 5'd1};

    localparam logic [2:0] PF_NONE     = 3'd0;
    localparam logic [2:0] PF_MISS     = 3'd1;
    localparam logic [2:0] PF_SEQ_MISS = 3'd2;
    localparam logic [2:0] PF_FULL_HIT = 3'd3;
    localparam logic [2:0] PF_PART_HIT = 3'd4;

    typedef struct packed {
        logic [31:0] address;
        logic        func;
        logic [1:0]  size;
    } access_t;

    typedef struct packed {
        logic [4:0] wait_cycles;
        logic [2:0] prefetch_outcome;
        logic [3:0] prefetch_level;
    } result_t;

    function automatic logic is_rom(input logic [3:0] region);
        return (region >= REGION_ROM_LO) && (region <= REGION_ROM_HI);
    endfunction

    // 16-bit access wait for a region; seq selects the ROM sequential timing
    function automatic logic [4:0] wait16(input logic [14:0] wc, input logic [3:0] ew,
                                          input logic [3:0] region, input logic seq);
        logic [1:0] fsel;
        logic       sbit;
        logic [4:0] w;
        unique case (region[2:1])
            2'b00:   begin fsel = wc[3:2]; sbit = wc[4];  end
            2'b01:   begin fsel = wc[6:5]; sbit = wc[7];  end
            default: begin fsel = wc[9:8]; sbit = wc[10]; end
        endcase
        priority if (region == REGION_WRAM_EXT) begin
            w = (ew == EWRAM_KEEP_DEFAULT) ? EWRAM_DEFAULT_WAIT : 5'd15 - {1'b0, ew};
        end else if (region >= REGION_BACKUP) begin
            w = FIRST_WAIT[wc[1:0]];
        end else if (is_rom(region)) begin
            w = seq ? SEQ_WAIT[{region[2:1], sbit}] : FIRST_WAIT[fsel];
        end else begin
            w = 5'd0;
        end
        return w;
    endfunction

    // 32-bit access wait: two bus halves
    function automatic logic [4:0] wait32(input logic [14:0] wc, input logic [3:0] ew,
                                          input logic [3:0] region, input logic seq);
        logic [4:0] f;
        logic [4:0] s;
        logic [4:0] w;
        f = wait16(wc, ew, region, 1'b0);
        s = wait16(wc, ew, region, 1'b1);
        priority if (region == REGION_WRAM_EXT || region >= REGION_BACKUP) begin
            w = 5'((f << 1) + 5'd1);
        end else if (region == REGION_PAL_RAM || region == REGION_VID_RAM) begin
            w = 5'd1;
        end else if (is_rom(region)) begin
            w = seq ? 5'((s << 1) + 5'd1) : 5'(f + 5'd1 + s);
        end else begin
            w = 5'd0;
        end
        return w;
    endfunction

endpackage

FILE: sv/bus_wait_state_prefetch_timer.sv
// Top level: bus access wait-state timer with a Game Pak style prefetch buffer.
// Steps: accept, evaluate, then for data accesses to regions 0 to 7 that may fill
// the buffer a fill loop that ends with one closing check, then the result. The
// fill loop adds one halfword per cycle through a single subtract and compare.
// One request at a time; reset empties the buffer, sets wait control to 0 and EWRAM field 13.
module bus_wait_state_prefetch_timer
    import bwspt_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = 8
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   acc_valid,
    output logic                   acc_stall,
    input  access_t                acc,
    output logic                   res_valid,
    input  logic                   res_stall,
    output result_t                res,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // at least two bits so that a word's need of two halfwords fits
    localparam int unsigned CW = (BUFFER_DEPTH < 2) ? 2 : $clog2(BUFFER_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_FILL = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t       state_reg, state_next;
    logic [14:0]  wc_reg, wc_next;
    logic [3:0]   ew_reg, ew_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0]  head_reg, head_next;
    logic [31:0]  prev_addr_reg, prev_addr_next;
    logic [3:0]   prev_region_reg, prev_region_next;

    logic [31:0]  addr_reg, addr_next;
    logic         func_reg, func_next;
    logic         word_reg, word_next;
    logic [5:0]   avail_reg, avail_next;
    logic [3:0]   cost_reg, cost_next;
    logic [4:0]   wait_reg, wait_next;
    logic [2:0]   outcome_reg, outcome_next;

    logic [3:0]   region;
    logic [31:0]  aligned;
    logic [31:0]  step;
    logic [4:0]   wait_ns;
    logic [4:0]   wait_seq;
    logic         pf_on;
    logic         head_match;
    logic [CW-1:0] need;

    assign region     = addr_reg[27:24];
    assign aligned    = word_reg ? {addr_reg[31:2], 2'b00} : {addr_reg[31:1], 1'b0};
    assign step       = word_reg ? 32'd4 : 32'd2;
    assign pf_on      = wc_reg[PF_EN_BIT];
    assign wait_ns    = word_reg ? wait32(wc_reg, ew_reg, region, 1'b0)
                                 : wait16(wc_reg, ew_reg, region, 1'b0);
    assign wait_seq   = word_reg ? wait32(wc_reg, ew_reg, region, 1'b1)
                                 : wait16(wc_reg, ew_reg, region, 1'b1);
    assign head_match = pf_on && (aligned == head_reg);
    assign need       = word_reg ? CW'(2) : CW'(1);

    assign acc_stall = (state_reg != ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);
    // take register writes only between requests
    assign cfg_ready = (state_reg == ST_IDLE);

    assign res = '{wait_cycles: wait_reg, prefetch_outcome: outcome_reg,
                   prefetch_level: 4'(cnt_reg)};

    always_comb
    begin
        state_next       = state_reg;
        wc_next          = wc_reg;
        ew_next          = ew_reg;
        cnt_next         = cnt_reg;
        head_next        = head_reg;
        prev_addr_next   = prev_addr_reg;
        prev_region_next = prev_region_reg;
        addr_next        = addr_reg;
        func_next        = func_reg;
        word_next        = word_reg;
        avail_next       = avail_reg;
        cost_next        = cost_reg;
        wait_next        = wait_reg;
        outcome_next     = outcome_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc_valid)
                begin
                    addr_next  = acc.address;
                    func_next  = acc.func;
                    word_next  = acc.size[1];
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                wait_next    = wait_ns;
                outcome_next = PF_NONE;
                state_next   = ST_OUT;
                if (!func_reg)
                begin
                    if (!region[3])
                    begin
                        // free bus cycles may refill the buffer from the last ROM region
                        if (pf_on && is_rom(prev_region_reg))
                        begin
                            avail_next = 6'(wait_ns) + 6'd1;
                            cost_next  = 4'(wait16(wc_reg, ew_reg, prev_region_reg, 1'b1)) + 4'd1;
                            state_next = ST_FILL;
                        end
                    end
                    else
                    begin
                        cnt_next = '0;
                    end
                end
                else
                begin
                    if (is_rom(region))
                    begin
                        priority if (head_match && cnt_reg >= need)
                        begin
                            wait_next    = 5'd0;
                            head_next    = aligned + step;
                            cnt_next     = cnt_reg - need;
                            outcome_next = PF_FULL_HIT;
                        end
                        else if (word_reg && head_match && cnt_reg != '0)
                        begin
                            wait_next    = wait16(wc_reg, ew_reg, region, 1'b1);
                            head_next    = aligned + 32'd4;
                            cnt_next     = '0;
                            outcome_next = PF_PART_HIT;
                        end
                        else
                        begin
                            if (aligned == prev_addr_reg + step)
                            begin
                                wait_next    = wait_seq;
                                outcome_next = PF_SEQ_MISS;
                            end
                            else
                            begin
                                outcome_next = PF_MISS;
                            end
                            cnt_next  = '0;
                            head_next = aligned + step;
                        end
                    end
                    prev_region_next = region;
                    prev_addr_next   = aligned;
                end
            end
            ST_FILL:
            begin
                // one halfword per cycle while cycles and room remain
                if (avail_reg >= {2'b00, cost_reg} && cnt_reg < CW'(BUFFER_DEPTH))
                begin
                    avail_next = avail_reg - {2'b00, cost_reg};
                    cnt_next   = cnt_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!res_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_WAIT_CONTROL)
            begin
                wc_next = cfg_data;
                if (!cfg_data[PF_EN_BIT])
                begin
                    cnt_next = '0;
                end
            end
            else if (cfg_index == REG_EWRAM_WAIT)
            begin
                ew_next = cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            wc_reg          <= '0;
            ew_reg          <= EWRAM_RESET_FIELD;
            cnt_reg         <= '0;
            head_reg        <= '0;
            prev_addr_reg   <= '1;
            prev_region_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            wc_reg          <= wc_next;
            ew_reg          <= ew_next;
            cnt_reg         <= cnt_next;
            head_reg        <= head_next;
            prev_addr_reg   <= prev_addr_next;
            prev_region_reg <= prev_region_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        func_reg    <= func_next;
        word_reg    <= word_next;
        avail_reg   <= avail_next;
        cost_reg    <= cost_next;
        wait_reg    <= wait_next;
        outcome_reg <= outcome_next;
    end

    a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> acc_stall)
        else $error("request accepted while a result is pending");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(BUFFER_DEPTH))
        else $error("prefetch buffer count above depth");

    a_data_no_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !func_reg) |-> (res.prefetch_outcome == PF_NONE))
        else $error("data access reports a prefetch outcome");

    a_result_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> ($past(state_reg) == ST_CALC || $past(state_reg) == ST_FILL))
        else $error("result raised without evaluation");

    a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL && state_next == ST_FILL) |=> (cnt_reg == $past(cnt_reg) + CW'(1)))
        else $error("fill step did not add a halfword");

endmodule
